/* hw/rtl/rc4_stream_cipher_macros.svh */
// ---------------------------------------------------------------------------
// rc4 stream cipher assertion macros
// shared concurrent assertion forms for the cipher checkers
// ---------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// same-cycle implication, off while reset is low
`define RC4_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define RC4_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// property on the cycle after a reset cycle
`define RC4_ASSERT_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rc4_pkg.sv */
// ---------------------------------------------------------------------------
// rc4 package
// constants, control word layout and microcode program of the cipher engine
// ---------------------------------------------------------------------------
package rc4_pkg;

    // key store geometry
    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_CW    = $clog2(KEY_DEPTH + 1);

    // program counter
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    // permutation read address select
    typedef enum logic [1:0] {
        RA_I,
        RA_INC_I,
        RA_J_NEW,
        RA_SUM
    } t_raddr;

    // permutation write select
    typedef enum logic [1:0] {
        WR_NONE,
        WR_J_SI,
        WR_I_SJ
    } t_wsel;

    // index i operation
    typedef enum logic [1:0] {
        IX_HOLD,
        IX_INC,
        IX_CLR
    } t_iop;

    // index j operation
    typedef enum logic [1:0] {
        JX_HOLD,
        JX_ADD,
        JX_CLR
    } t_jop;

    // key store operation
    typedef enum logic [2:0] {
        KY_NONE,
        KY_APPEND,
        KY_REWIND,
        KY_STEP,
        KY_RELEASE
    } t_kop;

    // branch condition, taken branch loads the target step
    typedef enum logic [2:0] {
        BR_NEXT,
        BR_GOTO,
        BR_MSG,
        BR_MORE_KEY,
        BR_LOOP
    } t_br;

    // one control word
    typedef struct packed {
        logic   wait_in;
        logic   rd_en;
        t_raddr raddr;
        t_wsel  wsel;
        t_iop   iop;
        t_jop   jop;
        logic   use_key;
        logic   ld_si;
        logic   ld_sj;
        t_kop   kop;
        logic   clr_perm;
        logic   emit;
        t_br    br;
        t_step  target;
    } t_uop;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic func;
        logic last;
        logic i_max;
        logic out_free;
    } t_stat;

    // program steps
    localparam t_step ST_IDLE = 4'd0;
    localparam t_step ST_DISP = 4'd1;
    localparam t_step ST_KEY  = 4'd2;
    localparam t_step ST_SCH0 = 4'd3;
    localparam t_step ST_SCH1 = 4'd4;
    localparam t_step ST_SCH2 = 4'd5;
    localparam t_step ST_SCH3 = 4'd6;
    localparam t_step ST_SCH4 = 4'd7;
    localparam t_step ST_SCH5 = 4'd8;
    localparam t_step ST_MSG0 = 4'd9;
    localparam t_step ST_MSG1 = 4'd10;
    localparam t_step ST_MSG2 = 4'd11;
    localparam t_step ST_MSG3 = 4'd12;
    localparam t_step ST_MSG4 = 4'd13;
    localparam t_step ST_MSG5 = 4'd14;

    // microcode rom
    function automatic t_uop ucode(input t_step step);
        t_uop u;
        u        = '0;
        u.br     = BR_GOTO;
        u.target = ST_IDLE;
        unique case (step)
            ST_IDLE: begin
                u.wait_in = 1'b1;
                u.br      = BR_NEXT;
            end
            ST_DISP: begin
                u.br     = BR_MSG;
                u.target = ST_MSG0;
            end
            // append key byte, a last byte falls through to the schedule
            ST_KEY: begin
                u.kop    = KY_APPEND;
                u.br     = BR_MORE_KEY;
                u.target = ST_IDLE;
            end
            ST_SCH0: begin
                u.clr_perm = 1'b1;
                u.iop      = IX_CLR;
                u.jop      = JX_CLR;
                u.kop      = KY_REWIND;
                u.br       = BR_NEXT;
            end
            ST_SCH1: begin
                u.rd_en = 1'b1;
                u.raddr = RA_I;
                u.br    = BR_NEXT;
            end
            ST_SCH2: begin
                u.ld_si   = 1'b1;
                u.jop     = JX_ADD;
                u.use_key = 1'b1;
                u.rd_en   = 1'b1;
                u.raddr   = RA_J_NEW;
                u.br      = BR_NEXT;
            end
            ST_SCH3: begin
                u.ld_sj = 1'b1;
                u.wsel  = WR_J_SI;
                u.br    = BR_NEXT;
            end
            ST_SCH4: begin
                u.wsel   = WR_I_SJ;
                u.iop    = IX_INC;
                u.kop    = KY_STEP;
                u.br     = BR_LOOP;
                u.target = ST_SCH1;
            end
            ST_SCH5: begin
                u.iop = IX_CLR;
                u.jop = JX_CLR;
                u.kop = KY_RELEASE;
            end
            ST_MSG0: begin
                u.iop   = IX_INC;
                u.rd_en = 1'b1;
                u.raddr = RA_INC_I;
                u.br    = BR_NEXT;
            end
            ST_MSG1: begin
                u.ld_si = 1'b1;
                u.jop   = JX_ADD;
                u.rd_en = 1'b1;
                u.raddr = RA_J_NEW;
                u.br    = BR_NEXT;
            end
            ST_MSG2: begin
                u.ld_sj = 1'b1;
                u.wsel  = WR_J_SI;
                u.br    = BR_NEXT;
            end
            ST_MSG3: begin
                u.wsel = WR_I_SJ;
                u.br   = BR_NEXT;
            end
            ST_MSG4: begin
                u.rd_en = 1'b1;
                u.raddr = RA_SUM;
                u.br    = BR_NEXT;
            end
            ST_MSG5: begin
                u.emit = 1'b1;
            end
            default: begin
            end
        endcase
        return u;
    endfunction

endpackage

/* hw/rtl/rc4_seq.sv */
// ---------------------------------------------------------------------------
// rc4 sequencer
// step counter over the microcode rom with conditional jumps and stalls
// ---------------------------------------------------------------------------
module rc4_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rc4_pkg::t_stat i_stat,
    output rc4_pkg::t_uop  o_uop
);
    import rc4_pkg::*;

    t_step r_step;
    t_step n_step;
    t_uop  w_uop;
    logic  w_hold;
    logic  w_take;

    // control word of the current step
    assign w_uop = ucode(r_step);
    assign o_uop = w_uop;

    // hold on a missing input or a full output register
    assign w_hold = (w_uop.wait_in && !i_stat.in_valid) ||
                    (w_uop.emit && !i_stat.out_free);

    // branch condition
    always_comb begin
        unique case (w_uop.br)
            BR_NEXT:     w_take = 1'b0;
            BR_GOTO:     w_take = 1'b1;
            BR_MSG:      w_take = i_stat.func;
            BR_MORE_KEY: w_take = !i_stat.last;
            BR_LOOP:     w_take = !i_stat.i_max;
            default:     w_take = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        priority if (w_hold) begin
            n_step = r_step;
        end else if (w_take) begin
            n_step = w_uop.target;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* hw/rtl/rc4_dp.sv */
// ---------------------------------------------------------------------------
// rc4 datapath
// permutation and key memories, indices, swap registers and result register
// ---------------------------------------------------------------------------
module rc4_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rc4_pkg::t_uop  i_uop,
    output rc4_pkg::t_stat o_stat,
    input  logic           i_in_valid,
    input  logic           i_in_func,
    input  logic [7:0]     i_in_value,
    input  logic           i_in_last,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last
);
    import rc4_pkg::*;

    // captured input item
    logic       r_func;
    logic [7:0] r_value;
    logic       r_last;

    // generator indices and swap operands
    logic [7:0] r_i;
    logic [7:0] r_j;
    logic [7:0] r_si;
    logic [7:0] r_sj;

    // permutation memory, entries not yet written read as their own index
    logic [7:0]   r_perm_mem [256];
    logic [255:0] r_perm_vld;
    logic [7:0]   r_rd_data;
    logic [7:0]   r_rd_addr;
    logic         r_rd_vld;

    // key store
    logic [7:0]        r_key_mem [KEY_DEPTH];
    logic [7:0]        r_key_q;
    logic [KEY_AW-1:0] r_k;
    logic [KEY_CW-1:0] r_kcount;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [7:0]        w_perm_q;
    logic [7:0]        w_j_new;
    logic [7:0]        w_raddr;
    logic              w_wen;
    logic [7:0]        w_waddr;
    logic [7:0]        w_wdata;
    logic              w_key_wen;
    logic [KEY_CW-1:0] w_k_inc;
    logic              w_k_wrap;
    logic              w_out_free;
    logic              w_emit;

    assign w_perm_q   = r_rd_vld ? r_rd_data : r_rd_addr;
    assign w_j_new    = r_j + w_perm_q + (i_uop.use_key ? r_key_q : 8'h00);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = i_uop.emit && w_out_free;
    assign w_key_wen  = (i_uop.kop == KY_APPEND) && (r_kcount < KEY_CW'(KEY_DEPTH));
    assign w_k_inc    = KEY_CW'(r_k) + KEY_CW'(1);
    assign w_k_wrap   = (w_k_inc == r_kcount);

    // permutation read address
    always_comb begin
        unique case (i_uop.raddr)
            RA_I:     w_raddr = r_i;
            RA_INC_I: w_raddr = r_i + 8'd1;
            RA_J_NEW: w_raddr = w_j_new;
            RA_SUM:   w_raddr = r_si + r_sj;
            default:  w_raddr = r_i;
        endcase
    end

    // permutation write port
    always_comb begin
        unique case (i_uop.wsel)
            WR_J_SI: begin
                w_wen   = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
            end
            WR_I_SJ: begin
                w_wen   = 1'b1;
                w_waddr = r_i;
                w_wdata = r_sj;
            end
            default: begin
                w_wen   = 1'b0;
                w_waddr = r_i;
                w_wdata = r_sj;
            end
        endcase
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_uop.wait_in && i_in_valid) begin
            r_func  <= i_in_func;
            r_value <= i_in_value;
            r_last  <= i_in_last;
        end
    end

    // permutation memory write
    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_perm_mem[w_waddr] <= w_wdata;
        end
    end

    // permutation memory read, registered
    always_ff @(posedge i_clk) begin
        if (i_uop.rd_en) begin
            r_rd_data <= r_perm_mem[w_raddr];
            r_rd_vld  <= r_perm_vld[w_raddr];
            r_rd_addr <= w_raddr;
        end
    end

    // written flags, cleared at once to restore the identity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_vld <= '0;
        end else if (i_uop.clr_perm) begin
            r_perm_vld <= '0;
        end else if (w_wen) begin
            r_perm_vld[w_waddr] <= 1'b1;
        end
    end

    // key store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_key_wen) begin
            r_key_mem[r_kcount[KEY_AW-1:0]] <= r_value;
        end
        r_key_q <= r_key_mem[r_k];
    end

    // key length and key read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kcount <= '0;
            r_k      <= '0;
        end else begin
            unique case (i_uop.kop)
                KY_APPEND: begin
                    if (w_key_wen) begin
                        r_kcount <= r_kcount + KEY_CW'(1);
                    end
                end
                KY_REWIND:  r_k      <= '0;
                KY_STEP:    r_k      <= w_k_wrap ? '0 : w_k_inc[KEY_AW-1:0];
                KY_RELEASE: r_kcount <= '0;
                default: begin
                end
            endcase
        end
    end

    // generator indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else begin
            unique case (i_uop.iop)
                IX_INC:  r_i <= r_i + 8'd1;
                IX_CLR:  r_i <= '0;
                default: r_i <= r_i;
            endcase
            unique case (i_uop.jop)
                JX_ADD:  r_j <= w_j_new;
                JX_CLR:  r_j <= '0;
                default: r_j <= r_j;
            endcase
        end
    end

    // swap operands
    always_ff @(posedge i_clk) begin
        if (i_uop.ld_si) begin
            r_si <= w_perm_q;
        end
        if (i_uop.ld_sj) begin
            r_sj <= w_perm_q;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= r_value ^ w_perm_q;
            r_out_last <= r_last;
        end
    end

    // status to the sequencer
    assign o_stat.in_valid = i_in_valid;
    assign o_stat.func     = r_func;
    assign o_stat.last     = r_last;
    assign o_stat.i_max    = (r_i == 8'hFF);
    assign o_stat.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

/* hw/rtl/rc4_stream_cipher.sv */
// ---------------------------------------------------------------------------
// rc4 stream cipher
// microcoded rc4 engine: key byte append, key schedule, byte encryption
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata = value[7:0], tuser = func, tlast = last_byte
//  m_axis    out        tdata = out_byte[7:0], tlast = end_of_message
//
//  message byte: no new transfer until its result is emitted, as the single
//    permutation memory port serves three dependent reads and two swap writes
//  key byte: appended in the key step; a last key byte adds the schedule
//    (256 loop passes of 4 steps through the same memory port)
//  reset: synchronous, restores the identity permutation through written flags
//  a waiting result holds the sequencer only at its emit step
// ---------------------------------------------------------------------------
module rc4_stream_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] value
    input  logic       i_s_axis_tuser,   // [0] func
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);
    import rc4_pkg::*;

    t_uop  w_uop;
    t_stat w_stat;

    // input transfer taken only at the idle step
    assign o_s_axis_tready = w_uop.wait_in;

    // program sequencer
    rc4_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uop   (w_uop)
    );

    // datapath
    rc4_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (w_uop),
        .o_stat      (w_stat),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_func   (i_s_axis_tuser),
        .i_in_value  (i_s_axis_tdata),
        .i_in_last   (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

/* hw/rtl/rc4_stream_cipher_chk.sv */
// ---------------------------------------------------------------------------
// rc4 stream cipher checker
// port-level assertions, bound to the top level
// ---------------------------------------------------------------------------
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    // a stalled result holds its payload
    `RC4_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled result changed")

    // the engine works on one item at a time
    `RC4_ASSERT_NXT(a_in_gap, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken on back-to-back cycles")

    // no result can appear right after a transfer into an empty engine
    `RC4_ASSERT_NXT(a_no_early_out, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid, !o_m_axis_tvalid, "result too early")

    // reset empties the result register
    `RC4_ASSERT_RST(a_rst_out, i_clk, i_rst_n, !o_m_axis_tvalid, "result valid after reset")

endmodule

bind rc4_stream_cipher rc4_stream_cipher_chk u_chk (.*);

/* tb/sv/tb_rc4_stream_cipher.sv */
// ---------------------------------------------------------------------------
// rc4 stream cipher testbench
// drives key and message bytes over the input stream, keeps its own rc4
// permutation and key store to work out every output byte, and compares
// each output transfer with the oldest expected byte; three idle regimes
// ---------------------------------------------------------------------------
module tb_rc4_stream_cipher;

    import rc4_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int PHASE_ITEMS    = 430;

    // function select carried on tuser
    typedef enum bit {
        FN_KEY = 1'b0,
        FN_MSG = 1'b1
    } t_func;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_message;
    } t_cipher_out;

    // predictor of the cipher state plus the queue of expected output bytes
    class cipher_scoreboard;
        bit [7:0]    perm [256];
        bit [7:0]    keys [256];
        int unsigned key_count;
        bit [7:0]    idx_i;
        bit [7:0]    idx_j;
        t_cipher_out expected_bytes [$];
        int          errors;
        int          checked;
        int          schedules;

        function new();
            for (int n = 0; n < 256; n++) begin
                perm[n] = n[7:0];
                keys[n] = 8'h00;
            end
            key_count = 0;
            idx_i     = 8'h00;
            idx_j     = 8'h00;
            errors    = 0;
            checked   = 0;
            schedules = 0;
        endfunction

        // key schedule over the bytes held for the current key
        function void schedule_key();
            bit [7:0]    jj;
            bit [7:0]    t;
            int unsigned kidx;
            jj = 8'h00;
            for (int n = 0; n < 256; n++) perm[n] = n[7:0];
            for (int n = 0; n < 256; n++) begin
                kidx    = (key_count == 0) ? 0 : (n % key_count);
                jj      = jj + perm[n] + keys[kidx[7:0]];
                t       = perm[jj];
                perm[jj] = perm[n];
                perm[n] = t;
            end
            idx_i     = 8'h00;
            idx_j     = 8'h00;
            key_count = 0;
            schedules++;
        endfunction

        // accepted input transfer
        function void note_transfer(bit func, bit [7:0] value, bit last);
            bit [7:0]    t;
            bit [7:0]    sum;
            t_cipher_out r;
            if (func == FN_KEY) begin
                if (key_count < KEY_DEPTH) begin
                    keys[key_count[7:0]] = value;
                    key_count++;
                end
                if (last) schedule_key();
            end else begin
                idx_i       = idx_i + 8'd1;
                idx_j       = idx_j + perm[idx_i];
                t           = perm[idx_j];
                perm[idx_j] = perm[idx_i];
                perm[idx_i] = t;
                sum         = perm[idx_i] + perm[idx_j];
                r.out_byte       = value ^ perm[sum];
                r.end_of_message = last;
                expected_bytes   = {expected_bytes, r};
            end
        endfunction

        // accepted output transfer against the oldest expected byte
        function void check_output(logic [7:0] data, logic last);
            t_cipher_out e;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output transfer, actual data %02h last %b",
                         $time, data, last);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            checked++;
            if (data !== e.out_byte) begin
                $display("%0t: out_byte mismatch, expected %02h actual %02h",
                         $time, e.out_byte, data);
                errors++;
            end
            if (last !== e.end_of_message) begin
                $display("%0t: end_of_message mismatch, expected %b actual %b",
                         $time, e.end_of_message, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] value
    logic       i_s_axis_tuser;   // [0] func
    logic       i_s_axis_tlast;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [7:0] out_byte
    logic       o_m_axis_tlast;

    cipher_scoreboard sb = new();

    int src_idle_pct;
    int dst_idle_pct;
    int items_sent;
    int quiet_cycles;

    rc4_stream_cipher u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(99) >= dst_idle_pct);
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_transfer(i_s_axis_tuser, i_s_axis_tdata, i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_output(o_m_axis_tdata, o_m_axis_tlast);
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input t_func func, input logic [7:0] value, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = func;
        i_s_axis_tdata  = value;
        i_s_axis_tlast  = last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
    endtask

    task automatic send_key(input int len);
        for (int k = 0; k < len; k++) begin
            send_item(FN_KEY, 8'($urandom_range(255)), k == len - 1);
        end
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) begin
            send_item(FN_MSG, 8'($urandom_range(255)), k == len - 1);
        end
    endtask

    // random phase: mostly key then messages, some loose noise
    task automatic random_phase(input int phase);
        int start;
        int seq;
        int len;
        start = items_sent;
        seq   = 0;
        while (items_sent - start < PHASE_ITEMS) begin
            if (seq == 1 && phase == 0) begin
                // store filled exactly, last byte is the final entry
                send_key(KEY_DEPTH);
                send_message($urandom_range(4, 12));
            end else if (seq == 1 && phase == 1) begin
                // overflow, last byte arrives with the store full
                send_key(KEY_DEPTH + $urandom_range(1, 20));
                send_message($urandom_range(4, 12));
            end else if ($urandom_range(99) < 85) begin
                len = ($urandom_range(99) < 80) ? $urandom_range(1, 16) : $urandom_range(17, 40);
                send_key(len);
                repeat ($urandom_range(1, 3)) send_message($urandom_range(1, 24));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_item(t_func'($urandom_range(1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                end
            end
            seq++;
        end
    endtask

    // main sequence
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tuser  = FN_KEY;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        src_idle_pct    = 29;
        dst_idle_pct    = 61;
        items_sent      = 0;
        quiet_cycles    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // no key yet, identity permutation from reset
        send_item(FN_MSG, 8'h00, 1'b0);
        send_item(FN_MSG, 8'hff, 1'b0);
        send_item(FN_MSG, 8'ha5, 1'b1);
        // single zero key byte
        send_item(FN_KEY, 8'h00, 1'b1);
        send_item(FN_MSG, 8'h00, 1'b0);
        send_item(FN_MSG, 8'hff, 1'b1);
        // three byte key with extreme values
        send_item(FN_KEY, 8'hff, 1'b0);
        send_item(FN_KEY, 8'h00, 1'b0);
        send_item(FN_KEY, 8'hff, 1'b1);
        send_item(FN_MSG, 8'h5a, 1'b0);
        send_item(FN_MSG, 8'hff, 1'b0);
        send_item(FN_MSG, 8'h00, 1'b1);
        // key bytes split by a message still build one key
        send_item(FN_KEY, 8'h12, 1'b0);
        send_item(FN_MSG, 8'h34, 1'b1);
        send_item(FN_KEY, 8'h56, 1'b1);
        // stream runs on across message boundaries
        send_item(FN_MSG, 8'hff, 1'b1);
        send_item(FN_MSG, 8'h00, 1'b1);
        send_item(FN_MSG, 8'h80, 1'b0);
        send_item(FN_MSG, 8'h01, 1'b1);

        random_phase(0);
        src_idle_pct = 61;
        dst_idle_pct = 29;
        random_phase(1);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        random_phase(2);

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d input transfers, %0d key schedules, %0d output bytes checked",
                 items_sent, sb.schedules, sb.checked);
        $display("idle regimes: sender-heavy, receiver-heavy, none; %0d errors", sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
